### hw/rtl/at_status_line_parser_assert.svh
// Assertion macros used by the status line parser top level.
`ifndef AT_STATUS_LINE_PARSER_ASSERT_SVH
`define AT_STATUS_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ATSLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ATSLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### hw/rtl/atslp_pkg.sv
// Package with types, character codes and header tables of the status line parser.
`timescale 1ns / 1ps
package atslp_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned OUT_WIDTH       = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned PLAY_LEN  = 8;
  localparam int unsigned TRACK_LEN = 9;

  localparam logic [7:0] HDR_PLAY [PLAY_LEN] = '{
    8'h50, 8'h4C, 8'h41, 8'h59, 8'h53, 8'h54, 8'h41, 8'h54
  };
  localparam logic [7:0] HDR_TRACK [TRACK_LEN] = '{
    8'h54, 8'h52, 8'h41, 8'h43, 8'h4B, 8'h53, 8'h54, 8'h41, 8'h54
  };

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_DEAD   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FS_SKIP   = 2'd0,
    FS_DIGITS = 2'd1,
    FS_STOP   = 2'd2
  } field_stage_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLAY  = 2'd1,
    KIND_TRACK = 2'd2
  } kind_e;

  localparam logic [1:0] MATCH_PLAY  = 2'b01;
  localparam logic [1:0] MATCH_TRACK = 2'b10;
  localparam logic [1:0] MATCH_BOTH  = 2'b11;

  typedef struct packed {
    logic       feed;
    logic [1:0] sel;
    kind_e      kind;
  } hdr_ctrl_t;

endpackage

### hw/rtl/atslp_header.sv
// Line phase, header match and comma counting of the status line parser.
`timescale 1ns / 1ps
module atslp_header import atslp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       last_i,
  input  logic [7:0] byte_i,
  output hdr_ctrl_t  ctrl_o,
  output phase_e     phase_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [1:0] match_q, match_d;
  logic [1:0] comma_q, comma_d;
  logic [3:0] track_idx;
  logic       is_comma;

  assign track_idx = (pos_q < 4'(TRACK_LEN)) ? pos_q : 4'd0;
  assign is_comma  = (byte_i == CH_COMMA) && (comma_q < 2'd2);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    match_d = match_q;
    comma_d = comma_q;
    unique case (phase_q)
      PH_FIRST: begin
        phase_d = (byte_i == CH_PLUS) ? PH_HEADER : PH_DEAD;
      end
      PH_HEADER: begin
        if (byte_i == CH_EQ) begin
          if (match_q[0] && pos_q == 4'(PLAY_LEN)) begin
            match_d = MATCH_PLAY;
          end else if (match_q[1] && pos_q == 4'(TRACK_LEN)) begin
            match_d = MATCH_TRACK;
          end else begin
            match_d = 2'b00;
          end
          phase_d = (match_d != 2'b00) ? PH_DATA : PH_DEAD;
        end else begin
          if (pos_q >= 4'(PLAY_LEN) || HDR_PLAY[pos_q[2:0]] != byte_i) begin
            match_d[0] = 1'b0;
          end
          if (pos_q >= 4'(TRACK_LEN) || HDR_TRACK[track_idx] != byte_i) begin
            match_d[1] = 1'b0;
          end
          if (pos_q != 4'hF) begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      PH_DATA: begin
        if (is_comma) begin
          comma_d = comma_q + 2'd1;
        end
      end
      PH_DEAD: begin
      end
    endcase
  end

  always_comb begin
    ctrl_o.feed = (phase_q == PH_DATA) && !is_comma;
    ctrl_o.sel  = comma_q;
    ctrl_o.kind = KIND_NONE;
    if (phase_d == PH_DATA) begin
      if (match_d == MATCH_PLAY) begin
        ctrl_o.kind = KIND_PLAY;
      end else if (match_d == MATCH_TRACK && comma_d == 2'd2) begin
        ctrl_o.kind = KIND_TRACK;
      end
    end
  end

  assign phase_o = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      pos_q   <= 4'd0;
      match_q <= MATCH_BOTH;
      comma_q <= 2'd0;
    end else if (adv_i) begin
      if (last_i) begin
        phase_q <= PH_FIRST;
        pos_q   <= 4'd0;
        match_q <= MATCH_BOTH;
        comma_q <= 2'd0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        match_q <= match_d;
        comma_q <= comma_d;
      end
    end
  end

endmodule

### hw/rtl/atslp_field.sv
// Decimal field reader: whitespace skip, sign, saturating magnitude accumulation.
`timescale 1ns / 1ps
module atslp_field import atslp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   clear_i,
  input  logic                   feed_i,
  input  logic [7:0]             byte_i,
  output logic [VALUE_WIDTH-1:0] mag_o,
  output logic                   neg_o
);

  localparam logic [VALUE_WIDTH-1:0] MagCap = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  field_stage_e           stage_q, stage_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d, acc_mag;
  logic [VALUE_WIDTH+3:0] prod;
  logic [3:0]             dval;
  logic                   is_digit, is_space, is_sign;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_space = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
  assign is_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
  assign dval     = 4'(byte_i - CH_ZERO);

  assign prod    = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
                 + (VALUE_WIDTH+4)'(dval);
  assign acc_mag = (prod > {4'b0000, MagCap}) ? MagCap : prod[VALUE_WIDTH-1:0];

  always_comb begin
    stage_d = stage_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (feed_i) begin
      unique case (stage_q)
        FS_SKIP: begin
          if (is_space) begin
            stage_d = FS_SKIP;
          end else if (is_sign) begin
            neg_d   = (byte_i == CH_MINUS);
            stage_d = FS_DIGITS;
          end else if (is_digit) begin
            mag_d   = acc_mag;
            stage_d = FS_DIGITS;
          end else begin
            stage_d = FS_STOP;
          end
        end
        FS_DIGITS: begin
          if (is_digit) begin
            mag_d = acc_mag;
          end else begin
            stage_d = FS_STOP;
          end
        end
        FS_STOP: begin
          stage_d = FS_STOP;
        end
        default: begin
          stage_d = FS_STOP;
        end
      endcase
    end
  end

  assign mag_o = mag_d;
  assign neg_o = neg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= FS_SKIP;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else if (adv_i) begin
      if (clear_i) begin
        stage_q <= FS_SKIP;
        neg_q   <= 1'b0;
        mag_q   <= '0;
      end else begin
        stage_q <= stage_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
      end
    end
  end

endmodule

### hw/rtl/atslp_conv.sv
// Turn a stored sign and magnitude into a saturated signed value of output width.
`timescale 1ns / 1ps
module atslp_conv import atslp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0]    mag_i,
  input  logic                      neg_i,
  output logic signed [OUT_WIDTH-1:0] value_o
);

  localparam logic [VALUE_WIDTH-1:0] PosMax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic signed [VALUE_WIDTH-1:0] value;

  always_comb begin
    if (neg_i) begin
      value = signed'(-mag_i);
    end else if (mag_i[VALUE_WIDTH-1]) begin
      value = signed'(PosMax);
    end else begin
      value = signed'(mag_i);
    end
  end

  assign value_o = OUT_WIDTH'(value);

endmodule

### hw/rtl/at_status_line_parser.sv
// Each item waits in the input register until parsed; a line end loads the result register.
// Throughput: one byte item per cycle, held back only while a line end waits on an unaccepted result.
// The input register and the result register bound the per-byte parse logic.
// Reset restarts the line parser and clears the three stored values and both valid flags to zero.
// Top level of the status line parser.
`timescale 1ns / 1ps
module at_status_line_parser import atslp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] line_byte
  input  logic        s_axis_tlast_i,   // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [31:0] play_state, [63:32] elapsed_seconds,
                                        // [95:64] total_seconds
  output logic [1:0]  m_axis_tuser_o    // [1:0] update_kind
);

  `include "at_status_line_parser_assert.svh"

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   last_q;
  logic                   adv;
  logic                   out_valid_q;
  kind_e                  kind_q;
  hdr_ctrl_t              ctrl;
  phase_e                 phase;
  logic [VALUE_WIDTH-1:0] f_mag [3];
  logic                   f_neg [3];
  logic [VALUE_WIDTH-1:0] st_mag_q [3];
  logic                   st_neg_q [3];
  logic [OUT_WIDTH-1:0]   st_val [3];

  assign adv = in_valid_q && (!last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  atslp_header u_header (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .last_i  (last_q),
    .byte_i  (byte_q),
    .ctrl_o  (ctrl),
    .phase_o (phase)
  );

  for (genvar i = 0; i < 3; i++) begin : g_field
    atslp_field #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_field (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .clear_i (last_q),
      .feed_i  (ctrl.feed && (ctrl.sel == 2'(i))),
      .byte_i  (byte_q),
      .mag_o   (f_mag[i]),
      .neg_o   (f_neg[i])
    );

    atslp_conv #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
      .mag_i   (st_mag_q[i]),
      .neg_i   (st_neg_q[i]),
      .value_o (st_val[i])
    );
  end

  // Stored values change only on a line end, when the result slot is free or draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        st_mag_q[i] <= '0;
        st_neg_q[i] <= 1'b0;
      end
    end else if (adv && last_q) begin
      if (ctrl.kind == KIND_PLAY || ctrl.kind == KIND_TRACK) begin
        st_mag_q[0] <= f_mag[0];
        st_neg_q[0] <= f_neg[0];
      end
      if (ctrl.kind == KIND_TRACK) begin
        for (int i = 1; i < 3; i++) begin
          st_mag_q[i] <= f_mag[i];
          st_neg_q[i] <= f_neg[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
      kind_q      <= ctrl.kind;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {st_val[2], st_val[1], st_val[0]};

  `ATSLP_ASSERT_NXT(a_in_hold, in_valid_q && !adv, in_valid_q && $stable(byte_q) && $stable(last_q))
  `ATSLP_ASSERT_IMP(a_slot_free, adv && last_q, !out_valid_q || m_axis_tready_i)
  `ATSLP_ASSERT_NXT(a_store_quiet, !(adv && last_q), $stable(m_axis_tdata_o))
  `ATSLP_ASSERT_NXT(a_dead_stays, adv && !last_q && phase == PH_DEAD, phase == PH_DEAD)
  `ATSLP_ASSERT_IMP(a_kind_in_data, ctrl.kind != KIND_NONE, phase == PH_DATA || phase == PH_HEADER)

endmodule

### bench/at_status_line_parser_tb.sv
// Self-checking testbench for the status line parser: directed lines, then random lines.
`timescale 1ns / 1ps
module at_status_line_parser_tb;
  import atslp_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RAND_BYTES   = 650;
  localparam int          DRAIN_CYCLES = 20;
  localparam logic [1:0]  MATCH_NONE   = 2'b00;
  localparam longint unsigned MAG_CAP  = 64'd1 << (VALUE_WIDTH_DEF - 1);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] play;
    logic [31:0] elapsed;
    logic [31:0] total;
  } status_t;

  typedef struct {
    string   text;
    bit      typed;
    status_t st;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  at_status_line_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  row_t dir_rows [25] = '{
    '{"hello", 1'b1, '{KIND_NONE, 32'd0, 32'd0, 32'd0}},
    '{"+PLAYSTAT=3", 1'b1, '{KIND_PLAY, 32'd3, 32'd0, 32'd0}},
    '{"+TRACKSTAT=1,125,300", 1'b1, '{KIND_TRACK, 32'd1, 32'd125, 32'd300}},
    '{"+PLAYSTAT=99999999999", 1'b1, '{KIND_PLAY, 32'h7FFF_FFFF, 32'd125, 32'd300}},
    '{"+PLAYSTAT=-99999999999", 1'b1, '{KIND_PLAY, 32'h8000_0000, 32'd125, 32'd300}},
    '{"+TRACKSTAT=2,-2147483648,2147483647", 1'b1,
      '{KIND_TRACK, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF}},
    '{"+TRACKSTAT=5,6", 1'b1, '{KIND_NONE, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF}},
    '{"+PLAYSTAT", 1'b0, '0},
    '{"+=4", 1'b0, '0},
    '{"+PLAYSTA=4", 1'b0, '0},
    '{"+PLAYSTATS=4", 1'b0, '0},
    '{"+TRACKSTAT=9", 1'b0, '0},
    '{"+PLAYSTAT= \t\n-42abc", 1'b0, '0},
    '{"+PLAYSTAT=7,8", 1'b0, '0},
    '{"+PLAYSTAT=1=2", 1'b0, '0},
    '{"+PLAYSTAT=+", 1'b0, '0},
    '{"+PLAYSTAT=x5", 1'b0, '0},
    '{"+TRACKSTAT=\v+4,\f 61 ,3,2,1=0", 1'b0, '0},
    '{"+TRACKSTAT=,,", 1'b0, '0},
    '{"+PLAYSTAT=2147483648", 1'b0, '0},
    '{"+PLAYSTAT=-2147483648", 1'b0, '0},
    '{"+", 1'b0, '0},
    '{"x", 1'b0, '0},
    '{"+TRACKSTAT=\xff1,2,\x803", 1'b0, '0},
    '{"+TRACKSTAT\xff=1,2,3", 1'b0, '0}
  };

  // stored values and per-line parse state of the predictor
  logic [31:0]     st_play, st_elapsed, st_total;
  phase_e          ln_phase;
  int              hdr_pos;
  logic [1:0]      ln_match;
  int              ln_commas;
  longint unsigned fld_mag [3];
  field_stage_e    fld_stage [3];
  bit              fld_neg [3];

  status_t    status_q [$];
  logic [7:0] line_buf [$];

  int  errors = 0;
  int  results_seen = 0;
  int  kind_seen [3] = '{0, 0, 0};
  int  lines_sent = 0;
  int  bytes_sent = 0;
  int  cycle_cnt = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  hold_req = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_cnt % 600) < 200) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_line();
    ln_phase  = PH_FIRST;
    hdr_pos   = 0;
    ln_match  = MATCH_BOTH;
    ln_commas = 0;
    for (int i = 0; i < 3; i++) begin
      fld_mag[i]   = 0;
      fld_stage[i] = FS_SKIP;
      fld_neg[i]   = 1'b0;
    end
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void take_digit(int f, logic [7:0] c);
    longint unsigned d;
    d = c - CH_ZERO;
    if (fld_mag[f] > (MAG_CAP - d) / 10) fld_mag[f] = MAG_CAP;
    else fld_mag[f] = fld_mag[f] * 10 + d;
  endfunction

  function automatic void feed_field(int f, logic [7:0] c);
    bit digit;
    digit = c >= CH_ZERO && c <= CH_NINE;
    case (fld_stage[f])
      FS_SKIP: begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            fld_neg[f]   = c == CH_MINUS;
            fld_stage[f] = FS_DIGITS;
          end else if (digit) begin
            take_digit(f, c);
            fld_stage[f] = FS_DIGITS;
          end else begin
            fld_stage[f] = FS_STOP;
          end
        end
      end
      FS_DIGITS: begin
        if (digit) take_digit(f, c);
        else fld_stage[f] = FS_STOP;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [31:0] field_value(int f);
    logic [63:0] v;
    if (fld_neg[f]) v = 64'd0 - fld_mag[f];
    else if (fld_mag[f] >= MAG_CAP) v = MAG_CAP - 1;
    else v = fld_mag[f];
    return v[31:0];
  endfunction

  // advance the parse by one byte; return 1 with the status when the line ends
  function automatic bit parse_byte(logic [7:0] c, logic last, output status_t st);
    kind_e kind;
    st = '0;
    case (ln_phase)
      PH_FIRST: ln_phase = (c == CH_PLUS) ? PH_HEADER : PH_DEAD;
      PH_HEADER: begin
        if (c == CH_EQ) begin
          if ((ln_match & MATCH_PLAY) != MATCH_NONE && hdr_pos == PLAY_LEN)
            ln_match = MATCH_PLAY;
          else if ((ln_match & MATCH_TRACK) != MATCH_NONE && hdr_pos == TRACK_LEN)
            ln_match = MATCH_TRACK;
          else
            ln_match = MATCH_NONE;
          ln_phase = (ln_match != MATCH_NONE) ? PH_DATA : PH_DEAD;
        end else begin
          if (hdr_pos >= PLAY_LEN || HDR_PLAY[hdr_pos] != c) ln_match &= ~MATCH_PLAY;
          if (hdr_pos >= TRACK_LEN || HDR_TRACK[hdr_pos] != c) ln_match &= ~MATCH_TRACK;
          if (hdr_pos < 15) hdr_pos++;
        end
      end
      PH_DATA: begin
        if (c == CH_COMMA && ln_commas < 2) ln_commas++;
        else feed_field(ln_commas, c);
      end
      default: begin
      end
    endcase
    if (!last) return 1'b0;
    kind = KIND_NONE;
    if (ln_phase == PH_DATA) begin
      if (ln_match == MATCH_PLAY) begin
        st_play = field_value(0);
        kind    = KIND_PLAY;
      end else if (ln_match == MATCH_TRACK && ln_commas == 2) begin
        st_play    = field_value(0);
        st_elapsed = field_value(1);
        st_total   = field_value(2);
        kind       = KIND_TRACK;
      end
    end
    clear_line();
    st = '{kind, st_play, st_elapsed, st_total};
    return 1'b1;
  endfunction

  task automatic send_item(logic [7:0] c, logic last, bit typed, status_t typed_st);
    int      gap;
    status_t st;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    if (parse_byte(c, last, st)) status_q.push_back(typed ? typed_st : st);
  endtask

  task automatic send_line(logic [7:0] q [$], bit typed, status_t typed_st);
    for (int i = 0; i < q.size(); i++) send_item(q[i], i == q.size() - 1, typed, typed_st);
    lines_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait (status_q.size() == 0);
  endtask

  function automatic void push_str(string s);
    foreach (s[i]) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_field();
    int n;
    int r;
    n = $urandom_range(0, 2);
    repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    r = $urandom_range(0, 5);
    if (r == 0) line_buf.push_back(CH_PLUS);
    else if (r <= 2) line_buf.push_back(CH_MINUS);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // build one random line: mostly well-formed, the rest broken or noise
  function automatic void make_line();
    logic [7:0] hdr [$];
    string      s;
    int         r;
    int         pos;
    line_buf = {};
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if ($urandom_range(0, 1)) begin
        push_str("+PLAYSTAT=");
        add_field();
        if ($urandom_range(0, 5) == 0) begin
          line_buf.push_back(CH_COMMA);
          add_field();
        end
      end else begin
        push_str("+TRACKSTAT=");
        add_field();
        line_buf.push_back(CH_COMMA);
        add_field();
        line_buf.push_back(CH_COMMA);
        add_field();
        if ($urandom_range(0, 5) == 0) begin
          line_buf.push_back(CH_COMMA);
          add_field();
        end
      end
    end else if (r < 78) begin
      s = $urandom_range(0, 1) ? "PLAYSTAT" : "TRACKSTAT";
      foreach (s[i]) hdr.push_back(s[i]);
      pos = $urandom_range(0, hdr.size() - 1);
      case ($urandom_range(0, 2))
        0: hdr[pos] = 8'($urandom_range(0, 255));
        1: hdr.delete(pos);
        default: hdr.insert(pos, 8'($urandom_range(0, 255)));
      endcase
      line_buf.push_back(CH_PLUS);
      foreach (hdr[i]) line_buf.push_back(hdr[i]);
      line_buf.push_back(CH_EQ);
      add_field();
    end else if (r < 85) begin
      if ($urandom_range(0, 1)) begin
        push_str("+TRACKSTAT=");
        add_field();
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(CH_COMMA);
          add_field();
        end
      end else begin
        push_str($urandom_range(0, 1) ? "+PLAYSTAT" : "+TRACKSTAT");
        add_field();
      end
    end else begin
      if ($urandom_range(0, 1)) line_buf.push_back(CH_PLUS);
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic check_status();
    status_t exp_st;
    if (status_q.size() == 0) begin
      $error("status item with none expected: update_kind %0d", m_axis_tuser_o);
      errors++;
      return;
    end
    exp_st = status_q.pop_front();
    results_seen++;
    kind_seen[int'(exp_st.kind)]++;
    if (m_axis_tuser_o != exp_st.kind) begin
      $error("update_kind: expected %0d, got %0d", exp_st.kind, m_axis_tuser_o);
      errors++;
    end
    if (m_axis_tdata_o[31:0] != exp_st.play) begin
      $error("play_state: expected %0d, got %0d",
             $signed(exp_st.play), $signed(m_axis_tdata_o[31:0]));
      errors++;
    end
    if (m_axis_tdata_o[63:32] != exp_st.elapsed) begin
      $error("elapsed_seconds: expected %0d, got %0d",
             $signed(exp_st.elapsed), $signed(m_axis_tdata_o[63:32]));
      errors++;
    end
    if (m_axis_tdata_o[95:64] != exp_st.total) begin
      $error("total_seconds: expected %0d, got %0d",
             $signed(exp_st.total), $signed(m_axis_tdata_o[95:64]));
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) check_status();
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    logic [7:0] q [$];
    string      s;
    bit         held;
    bit         paused;
    int         rand_start;
    held   = 1'b0;
    paused = 1'b0;
    st_play    = '0;
    st_elapsed = '0;
    st_total   = '0;
    clear_line();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      q = {};
      s = dir_rows[r].text;
      foreach (s[i]) q.push_back(s[i]);
      send_line(q, dir_rows[r].typed, dir_rows[r].st);
    end
    drain();

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      if (!held && bytes_sent - rand_start >= 250) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && bytes_sent - rand_start >= 450) begin
        drain();
        paused = 1'b1;
      end
      make_line();
      send_line(line_buf, 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d lines (%0d bytes) with random gaps, a long result hold-off and a pause.",
             lines_sent, bytes_sent);
    $display("Checked %0d status items: %0d ignored, %0d play state, %0d track status.",
             results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
